// ===== hdl/cfpd_pkg.sv =====
// Shared types, constants and CRC helpers for the framed packet deframer.
`default_nettype none

package cfpd_pkg;

  localparam logic [7:0]  START_BYTE_RESET = 8'hA5;
  localparam logic [7:0]  CRC8_INIT        = 8'hFF;
  localparam logic [7:0]  CRC8_POLY        = 8'h8C;
  localparam logic [15:0] CRC16_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC16_POLY       = 16'h8408;

  // Header is start, length low, length high, sequence, header CRC.
  localparam logic [15:0] HDR_BYTES      = 16'd5;
  // Command id takes two bytes after the header.
  localparam logic [15:0] BODY_START     = 16'd7;
  localparam int          OVERHEAD_BYTES = 9;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [2:0] {
    ST_HUNT   = 3'd0,
    ST_LEN_LO = 3'd1,
    ST_LEN_HI = 3'd2,
    ST_SEQ    = 3'd3,
    ST_HCRC   = 3'd4,
    ST_BODY   = 3'd5
  } parse_step_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_offset;
    logic [15:0] command_id;
    logic [7:0]  payload_length;
    logic [7:0]  sequence_res;
    logic        crc_ok;
  } result_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cfpd_parser.sv =====
// Frame parser: header checks, CRC tracking and result generation, one byte per step.
`default_nettype none

module cfpd_parser #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        start_byte,
  input  wire logic              step_en,
  input  wire logic [7:0]        in_byte,
  output logic                   res_valid,
  output cfpd_pkg::result_t      res
);
  import cfpd_pkg::*;

  localparam int          POS_W     = $clog2(MAX_FRAME_BYTES);
  localparam logic [15:0] LEN_LIMIT = 16'(MAX_FRAME_BYTES - OVERHEAD_BYTES);

  parse_step_t       step, step_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [15:0]       length_value, length_value_next;
  logic [7:0]        header_crc, header_crc_next;
  logic [15:0]       frame_crc, frame_crc_next;
  logic [15:0]       command_word, command_word_next;
  logic [7:0]        sequence_value, sequence_value_next;
  logic [7:0]        received_crc_low, received_crc_low_next;

  logic [15:0] pos_ext;
  logic [15:0] body_end;
  logic [15:0] len_full;
  logic        len_ok;
  logic        hdr_ok;
  logic        is_start;
  logic        is_frame_end;
  logic [7:0]  crc8_val;
  logic [15:0] crc16_val;
  logic [15:0] offset_full;

  assign pos_ext      = {{(16-POS_W){1'b0}}, byte_position};
  assign body_end     = BODY_START + length_value;
  assign len_full     = {in_byte, length_value[7:0]};
  assign len_ok       = len_full < LEN_LIMIT;
  assign hdr_ok       = in_byte == header_crc;
  assign is_start     = in_byte == start_byte;
  assign is_frame_end = pos_ext > body_end;
  assign crc8_val     = crc8_step(header_crc, in_byte);
  assign crc16_val    = crc16_step(frame_crc, in_byte);
  assign offset_full  = pos_ext - BODY_START;

  // Next parse step
  always_comb begin
    step_next = step;
    if (step_en) begin
      unique case (step)
        ST_HUNT:   step_next = is_start ? ST_LEN_LO : ST_HUNT;
        ST_LEN_LO: step_next = ST_LEN_HI;
        ST_LEN_HI: step_next = len_ok ? ST_SEQ : ST_HUNT;
        ST_SEQ:    step_next = ST_HCRC;
        ST_HCRC:   step_next = hdr_ok ? ST_BODY : ST_HUNT;
        ST_BODY:   step_next = is_frame_end ? ST_HUNT : ST_BODY;
        default:   step_next = ST_HUNT;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    byte_position_next    = byte_position;
    length_value_next     = length_value;
    header_crc_next       = header_crc;
    frame_crc_next        = frame_crc;
    command_word_next     = command_word;
    sequence_value_next   = sequence_value;
    received_crc_low_next = received_crc_low;
    res_valid             = 1'b0;
    res.kind              = KIND_PAYLOAD;
    res.payload_byte      = 8'h00;
    res.payload_offset    = 8'h00;
    res.command_id        = command_word;
    res.payload_length    = length_value[7:0];
    res.sequence_res      = sequence_value;
    res.crc_ok            = 1'b0;
    if (step_en) begin
      unique case (step)
        ST_HUNT: begin
          if (is_start) begin
            header_crc_next    = crc8_step(CRC8_INIT, in_byte);
            frame_crc_next     = crc16_step(CRC16_INIT, in_byte);
            byte_position_next = POS_W'(1);
          end else begin
            byte_position_next = '0;
          end
        end
        ST_LEN_LO: begin
          length_value_next  = {8'h00, in_byte};
          header_crc_next    = crc8_val;
          frame_crc_next     = crc16_val;
          byte_position_next = byte_position + POS_W'(1);
        end
        ST_LEN_HI: begin
          length_value_next  = len_full;
          header_crc_next    = crc8_val;
          frame_crc_next     = crc16_val;
          byte_position_next = len_ok ? byte_position + POS_W'(1) : '0;
        end
        ST_SEQ: begin
          sequence_value_next = in_byte;
          header_crc_next     = crc8_val;
          frame_crc_next      = crc16_val;
          byte_position_next  = byte_position + POS_W'(1);
        end
        ST_HCRC: begin
          frame_crc_next     = crc16_val;
          byte_position_next = hdr_ok ? POS_W'(HDR_BYTES) : '0;
        end
        ST_BODY: begin
          priority if (pos_ext == HDR_BYTES) begin
            command_word_next  = {8'h00, in_byte};
            frame_crc_next     = crc16_val;
            byte_position_next = byte_position + POS_W'(1);
          end else if (pos_ext == HDR_BYTES + 16'd1) begin
            command_word_next  = {in_byte, command_word[7:0]};
            frame_crc_next     = crc16_val;
            byte_position_next = byte_position + POS_W'(1);
          end else if (pos_ext < body_end) begin
            frame_crc_next     = crc16_val;
            byte_position_next = byte_position + POS_W'(1);
            res_valid          = 1'b1;
            res.payload_byte   = in_byte;
            res.payload_offset = offset_full[7:0];
          end else if (pos_ext == body_end) begin
            received_crc_low_next = in_byte;
            byte_position_next    = byte_position + POS_W'(1);
          end else begin
            byte_position_next = '0;
            res_valid          = 1'b1;
            res.kind           = KIND_FRAME_END;
            res.crc_ok         = {in_byte, received_crc_low} == frame_crc;
          end
        end
        default: byte_position_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step             <= ST_HUNT;
      byte_position    <= '0;
      length_value     <= '0;
      header_crc       <= CRC8_INIT;
      frame_crc        <= CRC16_INIT;
      command_word     <= '0;
      sequence_value   <= '0;
      received_crc_low <= '0;
    end else begin
      step             <= step_next;
      byte_position    <= byte_position_next;
      length_value     <= length_value_next;
      header_crc       <= header_crc_next;
      frame_crc        <= frame_crc_next;
      command_word     <= command_word_next;
      sequence_value   <= sequence_value_next;
      received_crc_low <= received_crc_low_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cfpd_out_stage.sv =====
// Result register: holds one result and packs it onto the output stream.
`default_nettype none

module cfpd_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire cfpd_pkg::result_t res,
  output logic                   can_load,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [55:0]            m_tdata,
  output logic                   m_tuser
);
  import cfpd_pkg::*;

  result_t held;

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= res;
    end
  end

  assign m_tuser = held.kind;
  assign m_tdata = {7'b0, held.crc_ok, held.sequence_res, held.payload_length,
                    held.command_id, held.payload_offset, held.payload_byte};

endmodule

`default_nettype wire

// ===== hdl/crc_framed_packet_deframer.sv =====
// Top level of the framed packet deframer: input register, parser and result register.
//
//   channel | direction | request fields
//   s_*     | in        | tdata[7:0] rx_byte
//   m_*     | out       | tuser kind; tdata payload, offset, command id, length, seq, crc_ok
//   cfg_*   | in        | cfg_wr_data start_byte, written while cfg_wr_en is high
//
// One byte a cycle sustained while the output is not stalled; a request lands in the
// input register when it is taken, is parsed from there combinationally, and its result,
// if any, is captured in the result register and offered on m_*.
// The per-byte CRC8/CRC16 update and step decision set the cycle.
// rst clears the parser to hunting and empties both registers.
// A stalled output holds the input register; s_tready falls only while both are full.
`default_nettype none

module crc_framed_packet_deframer #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [7:0] payload_byte, [15:8] payload_offset,
                                      // [31:16] command_id, [39:32] payload_length,
                                      // [47:40] sequence_res, [48] crc_ok, rest zero
  output logic             m_tuser,   // [0] kind
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);
  import cfpd_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic [7:0]  start_byte;
  logic        can_load;
  logic        advance;
  logic        res_valid;
  result_t     res;

  assign advance  = in_valid && can_load;
  assign s_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
    end else if (cfg_wr_en) begin
      start_byte <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  cfpd_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .start_byte (start_byte),
    .step_en    (advance),
    .in_byte    (in_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  cfpd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_crc_framed_packet_deframer.sv =====
// Self-checking testbench for the framed packet deframer against a byte predictor.
module tb_crc_framed_packet_deframer;
  import cfpd_pkg::*;

  localparam int MAX_FRAME = 256;
  localparam int LEN_LIMIT = MAX_FRAME - OVERHEAD_BYTES;

  typedef enum int {
    FAULT_NONE,
    FAULT_HDR_CRC,
    FAULT_LENGTH,
    FAULT_BODY_CRC,
    FAULT_CUT
  } frame_fault_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;           // payload_byte, offset, command_id, length, seq, crc_ok
  logic        m_tuser;           // [0] kind
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;

  crc_framed_packet_deframer #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pending bytes, expected results and bookkeeping
  logic [7:0] rx_bytes_q[$];
  result_t    deframed_q[$];
  int         queued_cnt = 0;
  int         accepted_cnt = 0;
  int         results_seen = 0;
  int         err_cnt = 0;

  // Predictor state
  logic [7:0]  sof_byte = START_BYTE_RESET;
  parse_step_t pstep = ST_HUNT;
  int          pos = 0;
  logic [15:0] len_word = '0;
  logic [7:0]  hdr_crc = CRC8_INIT;
  logic [15:0] body_crc = CRC16_INIT;
  logic [15:0] cmd_word = '0;
  logic [7:0]  seq_byte = '0;
  logic [7:0]  crc_lo = '0;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ CRC8_POLY;
    end
    return crc;
  endfunction

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ CRC16_POLY;
    end
    return crc;
  endfunction

  task automatic absorb(input logic [7:0] b);
    hdr_crc = crc8_fold(hdr_crc, b);
    body_crc = crc16_fold(body_crc, b);
    pos++;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    result_t r;
    bit      emit;
    r = '0;
    emit = 1'b0;
    case (pstep)
      ST_HUNT: begin
        if (b == sof_byte) begin
          hdr_crc = crc8_fold(CRC8_INIT, b);
          body_crc = crc16_fold(CRC16_INIT, b);
          pos = 1;
          pstep = ST_LEN_LO;
        end else begin
          pos = 0;
        end
      end
      ST_LEN_LO: begin
        len_word = {8'h00, b};
        absorb(b);
        pstep = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        len_word[15:8] = b;
        absorb(b);
        if (int'(len_word) < LEN_LIMIT) begin
          pstep = ST_SEQ;
        end else begin
          pstep = ST_HUNT;
          pos = 0;
        end
      end
      ST_SEQ: begin
        seq_byte = b;
        absorb(b);
        pstep = ST_HCRC;
      end
      ST_HCRC: begin
        body_crc = crc16_fold(body_crc, b);
        pos = int'(HDR_BYTES);
        if (b == hdr_crc) begin
          pstep = ST_BODY;
        end else begin
          pstep = ST_HUNT;
          pos = 0;
        end
      end
      ST_BODY: begin
        if (pos < int'(BODY_START) + int'(len_word)) begin
          if (pos == int'(HDR_BYTES)) begin
            cmd_word = {8'h00, b};
          end else if (pos == int'(HDR_BYTES) + 1) begin
            cmd_word[15:8] = b;
          end else begin
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.payload_offset = 8'(pos - int'(BODY_START));
            emit = 1'b1;
          end
          body_crc = crc16_fold(body_crc, b);
          pos++;
        end else if (pos == int'(BODY_START) + int'(len_word)) begin
          crc_lo = b;
          pos++;
        end else begin
          r.kind = KIND_FRAME_END;
          r.crc_ok = ({b, crc_lo} == body_crc);
          emit = 1'b1;
          pstep = ST_HUNT;
          pos = 0;
        end
      end
      default: begin
        pstep = ST_HUNT;
        pos = 0;
      end
    endcase
    if (emit) begin
      r.command_id = cmd_word;
      r.payload_length = len_word[7:0];
      r.sequence_res = seq_byte;
      deframed_q.push_back(r);
    end
  endtask

  function automatic int pick_gap(inout int left, inout bit calm);
    int r;
    if (left == 0) begin
      calm = ($urandom_range(0, 99) < 30);
      left = $urandom_range(50, 300);
    end
    left--;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender: present queued bytes with random gaps, predict each accepted request
  int tx_gap = 0;
  int tx_left = 0;
  bit tx_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        deframe_byte(s_tdata);
        accepted_cnt++;
      end
      if (tx_gap != 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= rx_bytes_q.pop_front();
        tx_gap = pick_gap(tx_left, tx_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up
  int rx_hold = 0;
  int rx_left = 0;
  bit rx_calm = 1'b0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 400) begin
      long_hold_done = 1'b1;
      rx_hold = 400;
      m_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_hold = pick_gap(rx_left, rx_calm);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (deframed_q.size() == 0) begin
        $error("result with no expectation pending: tuser 0x%0h tdata 0x%0h", m_tuser, m_tdata);
        err_cnt++;
      end else begin
        want = deframed_q.pop_front();
        check_field("kind", want.kind, m_tuser);
        check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
        check_field("payload_offset", want.payload_offset, m_tdata[15:8]);
        check_field("command_id", want.command_id, m_tdata[31:16]);
        check_field("payload_length", want.payload_length, m_tdata[39:32]);
        check_field("sequence_res", want.sequence_res, m_tdata[47:40]);
        check_field("crc_ok", want.crc_ok, m_tdata[48]);
      end
    end
  end

  task automatic offer(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    queued_cnt++;
  endtask

  // Build one frame with the current start byte; fill < 0 means random payload
  task automatic queue_frame(input frame_fault_t fault, input int plen, input logic [15:0] cmd,
                             input logic [7:0] seq, input int fill);
    logic [7:0]  f[$];
    logic [15:0] lw;
    logic [15:0] fc;
    logic [7:0]  hc;
    int          cut;
    if (fault == FAULT_LENGTH) begin
      case ($urandom_range(0, 3))
        0: lw = 16'(LEN_LIMIT);
        1: lw = 16'hFFFF;
        2: lw = 16'h0100;
        default: lw = 16'($urandom_range(LEN_LIMIT, 65535));
      endcase
    end else begin
      lw = 16'(plen);
    end
    f.push_back(sof_byte);
    f.push_back(lw[7:0]);
    f.push_back(lw[15:8]);
    f.push_back(seq);
    hc = CRC8_INIT;
    foreach (f[i]) hc = crc8_fold(hc, f[i]);
    if (fault == FAULT_HDR_CRC) hc ^= 8'($urandom_range(1, 255));
    f.push_back(hc);
    f.push_back(cmd[7:0]);
    f.push_back(cmd[15:8]);
    for (int i = 0; i < plen; i++) f.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    fc = CRC16_INIT;
    foreach (f[i]) fc = crc16_fold(fc, f[i]);
    if (fault == FAULT_BODY_CRC) fc ^= 16'($urandom_range(1, 65535));
    f.push_back(fc[7:0]);
    f.push_back(fc[15:8]);
    if (fault == FAULT_CUT) begin
      cut = $urandom_range(1, f.size() - 1);
      while (f.size() > cut) void'(f.pop_back());
    end
    foreach (f[i]) offer(f[i]);
  endtask

  // Mostly well-formed frames, the rest faults and line noise
  task automatic queue_traffic(input int budget, input bit with_max);
    int          first;
    int          r;
    int          plen;
    logic [7:0]  b;
    first = queued_cnt;
    if (with_max) queue_frame(FAULT_NONE, LEN_LIMIT - 1, 16'($urandom), 8'($urandom), -1);
    while (queued_cnt - first < budget) begin
      r = $urandom_range(0, 99);
      plen = $urandom_range(0, 99);
      if (plen < 1) plen = $urandom_range(200, LEN_LIMIT - 1);
      else if (plen < 11) plen = $urandom_range(9, 40);
      else plen = $urandom_range(0, 8);
      if (r < 8) begin
        repeat ($urandom_range(1, 6)) begin
          do b = 8'($urandom); while (b == sof_byte);
          offer(b);
        end
      end else begin
        queue_frame(r < 14 ? FAULT_HDR_CRC :
                    r < 19 ? FAULT_LENGTH :
                    r < 27 ? FAULT_BODY_CRC :
                    r < 31 ? FAULT_CUT : FAULT_NONE,
                    plen, 16'($urandom), 8'($urandom), -1);
      end
    end
  endtask

  // Wait for every request and result, then let the pipeline empty
  task automatic drain();
    while (accepted_cnt != queued_cnt || deframed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sof_byte = v;
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: noise extremes, empty good frame, one-byte bad frame, oversize length
    offer(8'h00);
    offer(8'hFF);
    queue_frame(FAULT_NONE, 0, 16'hFFFF, 8'h00, -1);
    queue_frame(FAULT_BODY_CRC, 1, 16'h0000, 8'hFF, 8'hFF);
    offer(sof_byte);
    offer(8'(LEN_LIMIT));
    offer(8'(LEN_LIMIT >> 8));

    queue_traffic(310, 1'b0);
    drain();
    write_start(8'h00);
    queue_traffic(310, 1'b0);
    drain();
    write_start(8'hFF);
    queue_traffic(310, 1'b1);
    drain();
    write_start(8'($urandom_range(1, 254)));
    queue_traffic(310, 1'b0);
    drain();
    write_start(START_BYTE_RESET);
    queue_traffic(310, 1'b0);
    drain();

    if (err_cnt == 0) begin
      $display("tb_crc_framed_packet_deframer: clean");
    end else begin
      $display("tb_crc_framed_packet_deframer: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("tb_crc_framed_packet_deframer: errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cfpd_pkg.sv
hdl/cfpd_parser.sv
hdl/cfpd_out_stage.sv
hdl/crc_framed_packet_deframer.sv
tb/sv/tb_crc_framed_packet_deframer.sv
